// ----- design/assert_macros.svh -----
// Assertion macros used by the port checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, switched off while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication that is also checked during reset.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// ----- design/glt_pkg.sv -----
`timescale 1ns / 1ps

package glt_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Depth of the sent-byte store; the banked store relies on a power of two.
    localparam int FIFO_BYTES = 1024;
    localparam int FIFO_AW    = $clog2(FIFO_BYTES);

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWEST_NOTE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST_NOTE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GO_DOWN      = 3'd4;

    localparam logic [15:0] TICK_PERIOD_RST  = 16'd200;
    localparam logic [6:0]  LOWEST_NOTE_RST  = 7'd60;
    localparam logic [6:0]  HIGHEST_NOTE_RST = 7'd72;
    localparam logic [6:0]  STEP_SIZE_RST    = 7'd1;
    localparam logic [6:0]  NOTE_RST         = 7'd60;

    localparam logic [7:0] ST_NOTE_ON  = 8'h90;
    localparam logic [7:0] VEL_ON      = 8'd64;
    localparam logic [7:0] ST_ALARM    = 8'haa;
    localparam logic [6:0] D1_ALARM    = 7'h7f;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_RX    = 2'd1,
        ACT_START = 2'd2,
        ACT_STOP  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_NOTE     = 2'd0,
        KIND_ALARM    = 2'd1,
        KIND_STOP_OFF = 2'd2
    } kind_t;

    typedef struct packed {
        logic [15:0] tick_period;
        logic [6:0]  lowest_note;
        logic [6:0]  highest_note;
        logic [6:0]  step_size;
        logic        go_down;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  status;
        logic [6:0]  data1;
        logic [6:0]  data2;
        logic [23:0] expected;
        logic        sent_short;
        logic        last;
    } result_t;

    // Up to three consecutive bytes appended to the sent-byte store.
    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } wr_req_t;

endpackage

// ----- design/glt_byte_store.sv -----
`timescale 1ns / 1ps

module glt_byte_store #(
    parameter int ADDR_W = 10
) (
    input  logic                 aclk,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  glt_pkg::wr_req_t     wr,
    output logic [47:0]          rd_window
);
    import glt_pkg::*;

    localparam int BANKS = 8;
    localparam int ROW_W = ADDR_W - 3;
    localparam int ROWS  = 1 << ROW_W;

    logic [7:0] bank_q [BANKS];
    logic [2:0] rd_lo_reg;

    // Eight byte-wide banks interleaved on the low address bits, so that any six
    // consecutive bytes lie in distinct banks and can be read together.
    for (genvar b = 0; b < BANKS; b++) begin : g_bank
        logic [7:0]        mem [ROWS];
        logic [2:0]        rd_off;
        logic [2:0]        wr_off;
        logic [ADDR_W-1:0] rd_a;
        logic [ADDR_W-1:0] wr_a;
        logic              we;
        logic [7:0]        wd;
        logic [7:0]        q_reg;
        logic [7:0]        byp_data_reg;
        logic              byp_reg;

        assign rd_off = 3'(b) - rd_addr[2:0];
        assign wr_off = 3'(b) - wr_addr[2:0];
        assign rd_a   = rd_addr + ADDR_W'(rd_off);
        assign wr_a   = wr_addr + ADDR_W'(wr_off);
        assign we     = wr_off < {1'b0, wr.cnt};

        always_comb begin
            priority if (wr_off == 3'd0) begin
                wd = wr.b0;
            end else if (wr_off == 3'd1) begin
                wd = wr.b1;
            end else begin
                wd = wr.b2;
            end
        end

        always_ff @(posedge aclk) begin
            if (we) begin
                mem[wr_a[ADDR_W-1:3]] <= wd;
            end
            if (rd_en) begin
                q_reg        <= mem[rd_a[ADDR_W-1:3]];
                byp_reg      <= we && (wr_a[ADDR_W-1:3] == rd_a[ADDR_W-1:3]);
                byp_data_reg <= wd;
            end
        end

        // A byte written in the same cycle as it is read comes from the bypass.
        assign bank_q[b] = byp_reg ? byp_data_reg : q_reg;
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_lo_reg <= rd_addr[2:0];
        end
    end

    always_comb begin
        for (int j = 0; j < 6; j++) begin
            rd_window[8*j +: 8] = bank_q[3'(rd_lo_reg + 3'(j))];
        end
    end

endmodule

// ----- design/glt_result_queue.sv -----
`timescale 1ns / 1ps

module glt_result_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        push_cnt,
    input  glt_pkg::result_t  push0,
    input  glt_pkg::result_t  push1,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output glt_pkg::result_t  out_data
);
    import glt_pkg::*;

    localparam int DEPTH = 4;
    localparam int IDX_W = $clog2(DEPTH);

    result_t            slot_reg [DEPTH];
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]   wr_idx_reg, wr_idx_next;
    logic [IDX_W:0]     fill_reg, fill_next;
    logic               pop;

    assign out_valid = fill_reg != '0;
    assign out_data  = slot_reg[rd_idx_reg];
    assign pop       = out_valid && out_ready;
    // Space for the two results that one item may cause.
    assign room      = fill_reg <= (IDX_W+1)'(DEPTH - 2);

    always_comb begin
        wr_idx_next = wr_idx_reg + IDX_W'(push_cnt);
        rd_idx_next = rd_idx_reg + IDX_W'(pop);
        fill_next   = fill_reg + (IDX_W+1)'(push_cnt) - (IDX_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
            fill_reg   <= '0;
        end else begin
            rd_idx_reg <= rd_idx_next;
            wr_idx_reg <= wr_idx_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            slot_reg[wr_idx_reg] <= push0;
        end
        if (push_cnt == 2'd2) begin
            slot_reg[IDX_W'(wr_idx_reg + IDX_W'(1))] <= push1;
        end
    end

endmodule

// ----- design/glt_engine.sv -----
`timescale 1ns / 1ps

module glt_engine (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              fire,
    input  glt_pkg::action_t                  action,
    input  logic [23:0]                       rx_msg,
    input  glt_pkg::cfg_t                     cfg,
    input  logic [47:0]                       rd_window,
    output logic [glt_pkg::FIFO_AW-1:0]       rd_ptr_next,
    output logic [glt_pkg::FIFO_AW-1:0]       wr_addr,
    output glt_pkg::wr_req_t                  wr,
    output logic [1:0]                        res_cnt,
    output glt_pkg::result_t                  res0,
    output glt_pkg::result_t                  res1
);
    import glt_pkg::*;

    localparam int AW = FIFO_AW;
    localparam int CW = $clog2(FIFO_BYTES + 1);

    logic          running_reg, running_next;
    logic          sounding_reg, sounding_next;
    logic [6:0]    note_reg, note_next;
    logic [15:0]   tick_reg, tick_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [23:0]   held_reg, held_next;

    logic [15:0]       tick_inc;
    logic [CW-1:0]     free_bytes;
    logic [1:0]        put_cnt;
    logic [7:0]        vel;
    logic signed [8:0] note_step, note_wrap1, note_wrap2;
    logic              have_first, have_second, mismatch, drop_second;
    logic [23:0]       first_exp, second_exp, cmp_exp;
    logic [2:0]        rd_adv;
    result_t           note_res, alarm_res, stop_res;

    assign wr_addr = wr_ptr_reg;

    assign tick_inc   = tick_reg + 16'd1;
    assign free_bytes = CW'(FIFO_BYTES) - count_reg;
    assign put_cnt    = (free_bytes >= CW'(3)) ? 2'd3 : free_bytes[1:0];
    assign vel        = sounding_reg ? 8'd0 : VEL_ON;

    assign note_step  = cfg.go_down ? $signed({2'b00, note_reg}) - $signed({2'b00, cfg.step_size})
                                    : $signed({2'b00, note_reg}) + $signed({2'b00, cfg.step_size});
    assign note_wrap1 = (note_step > $signed({2'b00, cfg.highest_note}))
                        ? $signed({2'b00, cfg.lowest_note}) : note_step;
    assign note_wrap2 = (note_wrap1 < $signed({2'b00, cfg.lowest_note}))
                        ? $signed({2'b00, cfg.highest_note}) : note_wrap1;

    // The window holds the six bytes from the read pointer, oldest in the low byte.
    assign first_exp   = {rd_window[7:0], rd_window[15:8], rd_window[23:16]};
    assign second_exp  = {rd_window[31:24], rd_window[39:32], rd_window[47:40]};
    assign have_first  = count_reg >= CW'(3);
    assign have_second = count_reg >= CW'(6);
    assign cmp_exp     = have_first ? first_exp : held_reg;
    assign mismatch    = cmp_exp != rx_msg;
    assign drop_second = mismatch && have_second;
    assign rd_adv      = (have_first ? 3'd3 : 3'd0) + (drop_second ? 3'd3 : 3'd0);

    always_comb begin
        note_res            = '0;
        note_res.kind       = KIND_NOTE;
        note_res.status     = ST_NOTE_ON;
        note_res.data1      = note_reg;
        note_res.data2      = vel[6:0];
        note_res.last       = 1'b1;

        alarm_res            = '0;
        alarm_res.kind       = KIND_ALARM;
        alarm_res.status     = ST_ALARM;
        alarm_res.data1      = D1_ALARM;
        alarm_res.expected   = cmp_exp;
        alarm_res.sent_short = !have_first;
        alarm_res.last       = !sounding_reg;

        stop_res            = '0;
        stop_res.kind       = KIND_STOP_OFF;
        stop_res.status     = ST_NOTE_ON;
        stop_res.data1      = note_reg;
        stop_res.last       = 1'b1;
    end

    always_comb begin
        running_next  = running_reg;
        sounding_next = sounding_reg;
        note_next     = note_reg;
        tick_next     = tick_reg;
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        count_next    = count_reg;
        held_next     = held_reg;
        wr            = '0;
        res_cnt       = 2'd0;
        res0          = note_res;
        res1          = stop_res;

        if (fire) begin
            unique case (action)
                ACT_TICK: begin
                    if (running_reg) begin
                        tick_next = tick_inc;
                        // A zero period still expires, since any count is at least zero.
                        if (tick_inc >= cfg.tick_period) begin
                            tick_next     = '0;
                            sounding_next = !sounding_reg;
                            res_cnt       = 2'd1;
                            wr.cnt        = put_cnt;
                            wr.b0         = ST_NOTE_ON;
                            wr.b1         = {1'b0, note_reg};
                            wr.b2         = vel;
                            wr_ptr_next   = wr_ptr_reg + AW'(put_cnt);
                            count_next    = count_reg + CW'(put_cnt);
                            if (sounding_reg) begin
                                note_next = note_wrap2[6:0];
                            end
                        end
                    end
                end
                ACT_RX: begin
                    rd_ptr_next = rd_ptr_reg + AW'(rd_adv);
                    count_next  = count_reg - CW'(rd_adv);
                    held_next   = drop_second ? second_exp : cmp_exp;
                    if (mismatch) begin
                        res0          = alarm_res;
                        res_cnt       = sounding_reg ? 2'd2 : 2'd1;
                        sounding_next = 1'b0;
                        running_next  = 1'b0;
                    end
                end
                ACT_START: begin
                    running_next = 1'b1;
                    rd_ptr_next  = '0;
                    wr_ptr_next  = '0;
                    count_next   = '0;
                end
                ACT_STOP: begin
                    res0          = stop_res;
                    res_cnt       = sounding_reg ? 2'd1 : 2'd0;
                    sounding_next = 1'b0;
                    running_next  = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg  <= 1'b1;
            sounding_reg <= 1'b1;
            note_reg     <= NOTE_RST;
            tick_reg     <= '0;
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            count_reg    <= '0;
            held_reg     <= '0;
        end else begin
            running_reg  <= running_next;
            sounding_reg <= sounding_next;
            note_reg     <= note_next;
            tick_reg     <= tick_next;
            rd_ptr_reg   <= rd_ptr_next;
            wr_ptr_reg   <= wr_ptr_next;
            count_reg    <= count_next;
            held_reg     <= held_next;
        end
    end

endmodule

// ----- design/midi_gliss_loopback_tester.sv -----
// An accepted beat is registered and executes while the result queue has room; its results
// are registered in that queue, which drives the output. Throughput: one beat per cycle
// while the queue has room, set by the single six-byte read of the banked sent-byte store
// and the execute stage that updates all state at once. Results leave at most one per cycle.
// Reset (aresetn low, synchronous) clears control state and restores register defaults;
// the sent-byte store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module midi_gliss_loopback_tester (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // rx_status [7:0], rx_data1 [15:8], rx_data2 [23:16]
    input  logic [23:0]                      s_tdata,
    // action [1:0]
    input  logic [1:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // msg_status [7:0], msg_data1 [14:8], msg_data2 [21:15], expected_status [29:22],
    // expected_data1 [37:30], expected_data2 [45:38], sent_short [46], zero [47]
    output logic [47:0]                      m_tdata,
    // msg_kind [1:0]
    output logic [1:0]                       m_tuser,
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [glt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [glt_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import glt_pkg::*;

    localparam int AW = FIFO_AW;

    cfg_t          cfg_reg, cfg_next;
    logic          s1_valid_reg, s1_valid_next;
    action_t       s1_action_reg;
    logic [23:0]   s1_rx_reg;
    logic          s1_fire, s_accept, q_room;
    logic [AW-1:0] rd_ptr_next, wr_addr;
    wr_req_t       wr;
    logic [1:0]    res_cnt;
    result_t       res0, res1, out_res;
    logic [47:0]   rd_window;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_TICK_PERIOD:  cfg_next.tick_period  = cfg_data;
                CFG_LOWEST_NOTE:  cfg_next.lowest_note  = cfg_data[6:0];
                CFG_HIGHEST_NOTE: cfg_next.highest_note = cfg_data[6:0];
                CFG_STEP_SIZE:    cfg_next.step_size    = cfg_data[6:0];
                CFG_GO_DOWN:      cfg_next.go_down      = cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // The execute stage runs only while the result queue can take two results.
    assign s1_fire  = s1_valid_reg && q_room;
    assign s_tready = !s1_valid_reg || s1_fire;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        priority if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_fire) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tick_period  <= TICK_PERIOD_RST;
            cfg_reg.lowest_note  <= LOWEST_NOTE_RST;
            cfg_reg.highest_note <= HIGHEST_NOTE_RST;
            cfg_reg.step_size    <= STEP_SIZE_RST;
            cfg_reg.go_down      <= 1'b0;
            s1_valid_reg         <= 1'b0;
        end else begin
            cfg_reg      <= cfg_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_action_reg <= action_t'(s_tuser);
            s1_rx_reg     <= {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
        end
    end

    // The read for a new beat is addressed with the pointer left by the beat that
    // executes in the same cycle.
    glt_byte_store #(
        .ADDR_W (AW)
    ) u_store (
        .aclk      (aclk),
        .rd_en     (s_accept),
        .rd_addr   (rd_ptr_next),
        .wr_addr   (wr_addr),
        .wr        (wr),
        .rd_window (rd_window)
    );

    glt_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (s1_fire),
        .action      (s1_action_reg),
        .rx_msg      (s1_rx_reg),
        .cfg         (cfg_reg),
        .rd_window   (rd_window),
        .rd_ptr_next (rd_ptr_next),
        .wr_addr     (wr_addr),
        .wr          (wr),
        .res_cnt     (res_cnt),
        .res0        (res0),
        .res1        (res1)
    );

    glt_result_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (res_cnt),
        .push0     (res0),
        .push1     (res1),
        .room      (q_room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {1'b0, out_res.sent_short, out_res.expected[7:0],
                      out_res.expected[15:8], out_res.expected[23:16],
                      out_res.data2, out_res.data1, out_res.status};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule

// ----- design/glt_port_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module glt_port_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [47:0]                      m_tdata,
    input logic [1:0]                       m_tuser,
    input logic                             m_tlast
);
    import glt_pkg::*;

    logic        alarm_beat, plain_beat, stop_beat, out_stall;
    logic        alarm_body_ok, plain_body_ok, stop_body_ok;
    logic [50:0] out_word;

    assign alarm_beat    = m_tvalid && (m_tuser == KIND_ALARM);
    assign plain_beat    = m_tvalid && (m_tuser != KIND_ALARM);
    assign stop_beat     = m_tvalid && (m_tuser == KIND_STOP_OFF);
    assign out_stall     = m_tvalid && !m_tready;
    assign alarm_body_ok = (m_tdata[7:0] == ST_ALARM) && (m_tdata[14:8] == D1_ALARM)
                           && (m_tdata[21:15] == 7'd0);
    assign plain_body_ok = (m_tdata[7:0] == ST_NOTE_ON) && (m_tdata[46:22] == 25'd0);
    assign stop_body_ok  = m_tlast && (m_tdata[21:15] == 7'd0);
    assign out_word      = {m_tuser, m_tlast, m_tdata};

    // An alarm beat always carries the fixed alarm message.
    `ASSERT_NOW(a_alarm_body, aclk, aresetn, alarm_beat, alarm_body_ok)

    // Note beats, stop note-offs included, carry the note-on status and no expected bytes or short flag.
    `ASSERT_NOW(a_note_clean, aclk, aresetn, plain_beat, plain_body_ok)

    // The note off sent on stopping is silent and always ends the results of its beat.
    `ASSERT_NOW(a_stop_last, aclk, aresetn, stop_beat, stop_body_ok)

    // A stalled result beat holds.
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_tvalid && $stable(out_word))

    // Reset empties the result queue.
    `ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid)

endmodule

bind midi_gliss_loopback_tester glt_port_checker u_port_checker (.*);

// ----- verif/midi_gliss_loopback_tester_checker.sv -----
`timescale 1ns / 1ps

module midi_gliss_loopback_tester_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // rx_status [7:0], rx_data1 [15:8], rx_data2 [23:16]
    input  logic [23:0]                    s_tdata,
    // action [1:0]
    input  logic [1:0]                     s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // msg_status [7:0], msg_data1 [14:8], msg_data2 [21:15], expected_status [29:22],
    // expected_data1 [37:30], expected_data2 [45:38], sent_short [46], zero [47]
    input  logic [47:0]                    m_tdata,
    // msg_kind [1:0]
    input  logic [1:0]                     m_tuser,
    input  logic                           m_tlast,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [glt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [glt_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             pending
);

    import glt_pkg::*;

    localparam int SENT_DEPTH = 1024;

    logic [15:0] cfg_period;
    logic [6:0]  cfg_low;
    logic [6:0]  cfg_high;
    logic [6:0]  cfg_step;
    logic        cfg_down;

    logic        running;
    logic        sounding;
    logic [7:0]  note;
    logic [15:0] ticks;
    logic [7:0]  sent_mem [0:SENT_DEPTH-1];
    logic [9:0]  rd_ptr;
    logic [9:0]  wr_ptr;
    logic [10:0] queued;
    logic [23:0] held;

    result_t     owed_msgs [$];
    result_t     batch [0:1];
    int          n_batch;

    function automatic result_t make_msg(input kind_t kind, input logic [7:0] status,
                                         input logic [6:0] d1, input logic [6:0] d2,
                                         input logic [23:0] exp_bytes, input logic shrt);
        result_t r;
        r.kind       = kind;
        r.status     = status;
        r.data1      = d1;
        r.data2      = d2;
        r.expected   = exp_bytes;
        r.sent_short = shrt;
        r.last       = 1'b0;
        return r;
    endfunction

    task automatic queue_byte(input logic [7:0] b);
        // Bytes that do not fit are simply lost.
        if (queued < 11'(SENT_DEPTH)) begin
            sent_mem[wr_ptr] = b;
            wr_ptr = wr_ptr + 10'd1;
            queued = queued + 11'd1;
        end
    endtask

    task automatic pull_triplet();
        for (int i = 0; i < 3; i++) begin
            held = {held[15:0], sent_mem[rd_ptr]};
            rd_ptr = rd_ptr + 10'd1;
            queued = queued - 11'd1;
        end
    endtask

    task automatic silence();
        if (sounding) begin
            batch[n_batch] = make_msg(KIND_STOP_OFF, ST_NOTE_ON, note[6:0], 7'd0, 24'd0, 1'b0);
            n_batch++;
            sounding = 1'b0;
        end
        running = 1'b0;
    endtask

    task automatic predict_beat(input action_t act, input logic [23:0] got);
        int   next_note;
        logic shrt;
        n_batch = 0;
        case (act)
            ACT_TICK: begin
                if (running) begin
                    ticks = ticks + 16'd1;
                    // A zero period compares as always reached, so it acts like one.
                    if (ticks >= cfg_period) begin
                        ticks = 16'd0;
                        sounding = !sounding;
                        batch[0] = make_msg(KIND_NOTE, ST_NOTE_ON, note[6:0],
                                            sounding ? VEL_ON[6:0] : 7'd0, 24'd0, 1'b0);
                        n_batch = 1;
                        queue_byte(ST_NOTE_ON);
                        queue_byte(note);
                        queue_byte(sounding ? VEL_ON : 8'd0);
                        if (!sounding) begin
                            next_note = cfg_down ? int'(note) - int'(cfg_step)
                                                 : int'(note) + int'(cfg_step);
                            if (next_note > int'(cfg_high)) next_note = int'(cfg_low);
                            if (next_note < int'(cfg_low)) next_note = int'(cfg_high);
                            note = next_note[7:0];
                        end
                    end
                end
            end
            ACT_RX: begin
                // With fewer than three bytes queued the previous triplet is reused.
                shrt = (queued < 11'd3);
                if (!shrt) pull_triplet();
                if (held != got) begin
                    batch[0] = make_msg(KIND_ALARM, ST_ALARM, D1_ALARM, 7'd0, held, shrt);
                    n_batch = 1;
                    if (queued >= 11'd3) pull_triplet();
                    silence();
                end
            end
            ACT_START: begin
                running = 1'b1;
                rd_ptr = 10'd0;
                wr_ptr = 10'd0;
                queued = 11'd0;
            end
            ACT_STOP: begin
                silence();
            end
        endcase
        if (n_batch > 0) batch[n_batch-1].last = 1'b1;
        for (int i = 0; i < n_batch; i++) owed_msgs.push_back(batch[i]);
    endtask

    function automatic void compare_field(input string field, input logic [23:0] want,
                                          input logic [23:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            cfg_period = TICK_PERIOD_RST;
            cfg_low    = LOWEST_NOTE_RST;
            cfg_high   = HIGHEST_NOTE_RST;
            cfg_step   = STEP_SIZE_RST;
            cfg_down   = 1'b0;
            running    = 1'b1;
            sounding   = 1'b1;
            note       = {1'b0, NOTE_RST};
            ticks      = 16'd0;
            rd_ptr     = 10'd0;
            wr_ptr     = 10'd0;
            queued     = 11'd0;
            held       = 24'd0;
            owed_msgs.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TICK_PERIOD:  cfg_period = cfg_data;
                    CFG_LOWEST_NOTE:  cfg_low    = cfg_data[6:0];
                    CFG_HIGHEST_NOTE: cfg_high   = cfg_data[6:0];
                    CFG_STEP_SIZE:    cfg_step   = cfg_data[6:0];
                    CFG_GO_DOWN:      cfg_down   = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                predict_beat(action_t'(s_tuser), {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]});
            end
            if (m_tvalid && m_tready) begin
                if (owed_msgs.size() == 0) begin
                    $display("%0t: result beat with nothing expected, expected none, got kind %0d data %h",
                             $time, m_tuser, m_tdata);
                    fail_count++;
                end else begin
                    want = owed_msgs.pop_front();
                    compare_field("msg_kind", want.kind, m_tuser);
                    compare_field("msg_status", want.status, m_tdata[7:0]);
                    compare_field("msg_data1", want.data1, m_tdata[14:8]);
                    compare_field("msg_data2", want.data2, m_tdata[21:15]);
                    compare_field("expected_status", want.expected[23:16], m_tdata[29:22]);
                    compare_field("expected_data1", want.expected[15:8], m_tdata[37:30]);
                    compare_field("expected_data2", want.expected[7:0], m_tdata[45:38]);
                    compare_field("sent_short", want.sent_short, m_tdata[46]);
                    compare_field("last", want.last, m_tlast);
                end
            end
        end
        pending = owed_msgs.size();
    end

endmodule

// ----- verif/tb_midi_gliss_loopback_tester.sv -----
`timescale 1ns / 1ps

module tb_midi_gliss_loopback_tester;

    import glt_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd5;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [23:0]           s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [47:0]           m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int          fail_count;
    int          pending;

    // Notes seen leaving the block, kept as {status, data1, data2} for echoing back.
    logic [23:0] sent_notes [$];
    int          echo_rd = 0;
    int          alarms_seen = 0;
    int          alarms_known = 0;
    logic        halted = 1'b0;
    logic        calm = 1'b0;
    int          hold_asks = 0;

    midi_gliss_loopback_tester DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    midi_gliss_loopback_tester_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (m_tuser == KIND_NOTE) begin
                sent_notes.push_back({m_tdata[7:0], 1'b0, m_tdata[14:8], 1'b0, m_tdata[21:15]});
            end else if (m_tuser == KIND_ALARM) begin
                alarms_seen++;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver: random stalls, plus one long hold-off whenever the stimulus asks.
    initial begin
        int stall_left;
        int holds_done;
        m_tready = 1'b0;
        stall_left = 0;
        holds_done = 0;
        forever begin
            @(negedge aclk);
            if (hold_asks != holds_done) begin
                holds_done = hold_asks;
                stall_left = 400;
            end else if (stall_left == 0 && !calm && $urandom_range(0, 2) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Called at a falling edge; returns at the rising edge where the beat is taken.
    task automatic offer(input action_t act, input logic [23:0] word);
        s_tvalid = 1'b1;
        s_tuser = act;
        s_tdata = word;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic idle_gap();
        int gap;
        gap = calm ? 0 : pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value,
                             input int width);
        logic [15:0] word;
        // Bits above the register width carry junk, which must be ignored.
        word = 16'($urandom);
        word = ((word >> width) << width) | value;
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = word;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic begin_run();
        drain();
        echo_rd = sent_notes.size();
        alarms_known = alarms_seen;
        halted = 1'b0;
        offer(ACT_START, 24'($urandom));
    endtask

    task automatic send_echo(input bit flip);
        logic [23:0] word;
        int          pos;
        word = sent_notes[echo_rd];
        echo_rd++;
        if (flip) begin
            pos = $urandom_range(0, 23);
            word[pos] = ~word[pos];
        end
        offer(ACT_RX, {word[7:0], word[15:8], word[23:16]});
    endtask

    task automatic mixed_item();
        int          r;
        logic [23:0] word;
        // After an alarm the block has stopped and the echo sequence is out of step.
        if (alarms_seen != alarms_known) begin
            alarms_known = alarms_seen;
            echo_rd = sent_notes.size();
            halted = 1'b1;
        end
        r = $urandom_range(0, 99);
        word = 24'($urandom);
        if (halted && r < 25) begin
            begin_run();
        end else if (r >= 50 && r < 82 && echo_rd < sent_notes.size()) begin
            send_echo($urandom_range(0, 15) == 0);
        end else if (r < 82) begin
            offer(ACT_TICK, word);
        end else if (r < 90) begin
            offer(ACT_RX, word);
        end else if (r < 95) begin
            begin_run();
        end else begin
            halted = 1'b1;
            offer(ACT_STOP, word);
        end
    endtask

    task automatic run_phase(input logic [15:0] period, input logic [6:0] lo,
                             input logic [6:0] hi, input logic [6:0] stp, input logic dn,
                             input int n_items, input logic quiet, input logic fill_up,
                             input logic squeeze);
        drain();
        write_reg(CFG_TICK_PERIOD, period, 16);
        write_reg(CFG_LOWEST_NOTE, 16'(lo), 7);
        write_reg(CFG_HIGHEST_NOTE, 16'(hi), 7);
        write_reg(CFG_STEP_SIZE, 16'(stp), 7);
        write_reg(CFG_GO_DOWN, 16'(dn), 1);
        @(posedge aclk);
        calm = quiet;
        if (squeeze) hold_asks++;
        begin_run();
        for (int i = 0; i < n_items; i++) begin
            idle_gap();
            // Filling runs tick long enough for the sent-byte store to overflow.
            if (fill_up && i < 350) offer(ACT_TICK, 24'($urandom));
            else mixed_item();
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 24'd0;
        s_tuser = ACT_TICK;
        cfg_valid = 1'b0;
        cfg_index = CFG_TICK_PERIOD;
        cfg_data = 16'd0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Nothing queued yet, so receptions compare against the held bytes.
        idle_gap(); offer(ACT_RX, 24'h000000);
        idle_gap(); offer(ACT_RX, 24'hffffff);
        idle_gap(); offer(ACT_STOP, 24'hffffff);
        idle_gap(); offer(ACT_TICK, 24'h000000);
        idle_gap(); offer(ACT_RX, {8'h00, 8'h3c, 8'h90});
        idle_gap(); offer(ACT_START, 24'h5a5a5a);
        drain();
        write_reg(CFG_IDX_SPARE, 16'hffff, 16);
        write_reg(CFG_TICK_PERIOD, 16'd0, 16);
        repeat (3) begin
            idle_gap(); offer(ACT_TICK, 24'hffffff);
        end
        // Start while running keeps the note and the sounding state.
        begin_run();
        repeat (2) begin
            idle_gap(); offer(ACT_TICK, 24'h000000);
        end
        drain();
        send_echo(1'b0);
        idle_gap(); send_echo(1'b1);
        begin_run();
        idle_gap(); offer(ACT_TICK, 24'ha5a5a5);
        idle_gap(); offer(ACT_STOP, 24'h000000);
        idle_gap(); offer(ACT_STOP, 24'hffffff);

        run_phase(16'd1, 7'd60, 7'd72, 7'd1, 1'b0, 80, 1'b0, 1'b0, 1'b0);
        run_phase(16'd2, 7'd0, 7'd127, 7'd127, 1'b1, 70, 1'b0, 1'b0, 1'b0);
        run_phase(16'd3, 7'd100, 7'd20, 7'd5, 1'b0, 50, 1'b0, 1'b0, 1'b0);
        run_phase(16'd1, 7'd0, 7'd1, 7'd1, 1'b1, 50, 1'b1, 1'b0, 1'b0);
        run_phase(16'd65535, 7'd126, 7'd127, 7'd3, 1'b0, 30, 1'b0, 1'b0, 1'b0);
        run_phase(16'd1, 7'd30, 7'd90, 7'd7, 1'b1, 70, 1'b0, 1'b0, 1'b1);
        run_phase(16'd1, 7'd0, 7'd127, 7'd1, 1'b0, 380, 1'b0, 1'b1, 1'b0);
        run_phase(16'd5, 7'd40, 7'd80, 7'd12, 1'b0, 60, 1'b0, 1'b0, 1'b0);

        drain();
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("** midi_gliss_loopback_tester: PASSED **");
        end else begin
            $display("** midi_gliss_loopback_tester: FAILED **");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("** midi_gliss_loopback_tester: FAILED **");
        $finish;
    end

endmodule
